@@ hdl/dtd_pkg.sv @@
package dtd_pkg;

    // Fixed field widths of the item and result channels
    localparam int ModeBits = 2;
    localparam int IdBits   = 4;
    localparam int TimeW    = 32;

    // Depth of the command queue between the front and back parts
    localparam int CmdQueueDepth = 2;

    // Input mode codes
    localparam logic [ModeBits-1:0] MODE_SCHED  = 2'd0;
    localparam logic [ModeBits-1:0] MODE_CANCEL = 2'd1;
    localparam logic [ModeBits-1:0] MODE_POLL   = 2'd2;

    // Classified operation handed to the back part
    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_SCHED  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_POLL   = 2'd3
    } t_op;

    typedef struct packed {
        logic [ModeBits-1:0] mode;
        logic [IdBits-1:0]   task_id;
        logic [TimeW-1:0]    time_value;
    } t_item;

    typedef struct packed {
        t_op               op;
        logic [IdBits-1:0] slot;
        logic [TimeW-1:0]  tval;
    } t_cmd;

    typedef struct packed {
        logic              fired;
        logic [IdBits-1:0] fired_task;
        logic              last;
        logic              queue_empty;
        logic [TimeW-1:0]  next_deadline;
    } t_result;

endpackage

@@ hdl/dtd_stream_if.sv @@
interface dtd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/dtd_front.sv @@
module dtd_front #(
    parameter int TASK_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtd_stream_if.sink   i_item,
    dtd_stream_if.source o_cmd
);

    logic            r_vld;
    logic            n_vld;
    dtd_pkg::t_cmd   r_cmd;
    dtd_pkg::t_cmd   n_cmd;
    logic            id_ok;
    logic            take;

    assign take         = i_item.valid && i_item.ready;
    assign i_item.ready = !r_vld || o_cmd.ready;
    assign o_cmd.valid  = r_vld;
    assign o_cmd.payload = r_cmd;

    assign id_ok = ({28'd0, i_item.payload.task_id} < 32'(TASK_SLOTS));

    // Classify: out-of-range slots on a schedule or cancel and the unused mode become no-ops
    always_comb begin
        n_cmd.slot = i_item.payload.task_id;
        n_cmd.tval = i_item.payload.time_value;
        case (i_item.payload.mode)
            dtd_pkg::MODE_SCHED:  n_cmd.op = id_ok ? dtd_pkg::OP_SCHED : dtd_pkg::OP_NOP;
            dtd_pkg::MODE_CANCEL: n_cmd.op = id_ok ? dtd_pkg::OP_CANCEL : dtd_pkg::OP_NOP;
            dtd_pkg::MODE_POLL:   n_cmd.op = dtd_pkg::OP_POLL;
            default:              n_cmd.op = dtd_pkg::OP_NOP;
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        if (o_cmd.ready) begin
            n_vld = 1'b0;
        end
        if (take) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ hdl/dtd_fifo.sv @@
module dtd_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtd_stream_if.sink   i_cmd,
    dtd_stream_if.source o_cmd
);

    localparam int Depth = dtd_pkg::CmdQueueDepth;
    localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW    = $clog2(Depth + 1);

    dtd_pkg::t_cmd  r_mem [Depth];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           push;
    logic           pop;

    assign i_cmd.ready   = (r_count != CW'(Depth));
    assign o_cmd.valid   = (r_count != '0);
    assign o_cmd.payload = r_mem[r_rd_ptr];

    assign push = i_cmd.valid && i_cmd.ready;
    assign pop  = o_cmd.valid && o_cmd.ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Depth - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Depth - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd.payload;
        end
    end

endmodule

@@ hdl/dtd_back.sv @@
module dtd_back #(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtd_stream_if.sink   i_cmd,
    dtd_stream_if.source o_res
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_APPLY = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_bstate;

    t_bstate                r_state, n_state;
    dtd_pkg::t_op           r_op, n_op;
    logic [IW-1:0]          r_slot, n_slot;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_best_vld, n_best_vld;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    logic [TIME_BITS-1:0]   r_best_dl, n_best_dl;
    logic                   r_pend_vld, n_pend_vld;
    logic [IW-1:0]          r_pend_idx, n_pend_idx;
    logic [TASK_SLOTS-1:0]  r_armed, n_armed;
    logic                   r_out_vld, n_out_vld;
    dtd_pkg::t_result       r_out, n_out;

    logic [TIME_BITS-1:0]   r_mem [TASK_SLOTS];
    logic [TIME_BITS-1:0]   r_rd_data;
    logic                   rd_en;
    logic                   due;
    logic                   need_out;
    logic                   out_free;
    dtd_pkg::t_result       res;

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;
    assign out_free      = !r_out_vld || o_res.ready;

    // Soonest armed slot is due on a poll
    assign due = (r_op == dtd_pkg::OP_POLL) && r_best_vld && (r_best_dl <= r_now);
    // A poll that found its first due slot emits nothing yet
    assign need_out = !((r_op == dtd_pkg::OP_POLL) && !r_pend_vld && due);

    always_comb begin
        res.fired         = (r_op == dtd_pkg::OP_POLL) && r_pend_vld;
        res.fired_task    = res.fired ? dtd_pkg::IdBits'(r_pend_idx) : '0;
        res.last          = !due;
        res.queue_empty   = !r_best_vld;
        res.next_deadline = r_best_vld ? dtd_pkg::TimeW'(r_best_dl) : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_slot     = r_slot;
        n_now      = r_now;
        n_cnt      = r_cnt;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_best_vld = r_best_vld;
        n_best_idx = r_best_idx;
        n_best_dl  = r_best_dl;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_armed    = r_armed;
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        rd_en      = 1'b0;
        i_cmd.ready = 1'b0;

        if (o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_op       = i_cmd.payload.op;
                    n_slot     = IW'(i_cmd.payload.slot);
                    n_now      = TIME_BITS'(i_cmd.payload.tval);
                    n_pend_vld = 1'b0;
                    n_state    = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (r_op == dtd_pkg::OP_SCHED) begin
                    n_armed[r_slot] = 1'b1;
                end else if (r_op == dtd_pkg::OP_CANCEL) begin
                    n_armed[r_slot] = 1'b0;
                end
                n_cnt      = '0;
                n_best_vld = 1'b0;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                // Issue one read per cycle, compare the data in the cycle after
                if (r_cnt < CW'(TASK_SLOTS)) begin
                    rd_en     = 1'b1;
                    n_cnt     = r_cnt + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_cnt[IW-1:0];
                end
                // Strict compare in ascending order keeps the lower id on ties
                if (r_cmp_vld && r_armed[r_cmp_idx] &&
                    (!r_best_vld || (r_rd_data < r_best_dl))) begin
                    n_best_vld = 1'b1;
                    n_best_idx = r_cmp_idx;
                    n_best_dl  = r_rd_data;
                end
                if ((r_cnt == CW'(TASK_SLOTS)) && !r_cmp_vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!need_out || out_free) begin
                    if (need_out) begin
                        n_out_vld = 1'b1;
                        n_out     = res;
                    end
                    if (due) begin
                        // Disarm the due slot and rescan for the one after it
                        n_armed[r_best_idx] = 1'b0;
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_best_idx;
                        n_cnt      = '0;
                        n_best_vld = 1'b0;
                        n_state    = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_armed    <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_cmp_vld  <= n_cmp_vld;
            r_best_vld <= n_best_vld;
            r_pend_vld <= n_pend_vld;
            r_armed    <= n_armed;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_now      <= n_now;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_dl  <= n_best_dl;
        r_pend_idx <= n_pend_idx;
        r_out      <= n_out;
    end

    // Deadline memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_APPLY) && (r_op == dtd_pkg::OP_SCHED)) begin
            r_mem[r_slot] <= r_now;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_cnt[IW-1:0]];
        end
    end

endmodule

@@ hdl/deadline_task_dispatcher.sv @@
// Channel | Dir | Payload  | Fields
// i_cmd   | in  | t_item   | mode, task_id, time_value
// o_res   | out | t_result | fired, fired_task, last, queue_empty, next_deadline
//
// A schedule, cancel or no-op item makes one pass over the slot table in the back part.
// A poll that dispatches k tasks makes k + 1 passes: each result needs one full pass
// over the deadline memory, one slot per cycle.
// Reset (i_rst_n low, synchronous) disarms every slot and empties the queue.
// The front register and the two-entry queue keep taking items while the back
// part works; a stalled o_res holds the back part only when it has a result to post.
module deadline_task_dispatcher #(
    parameter int TASK_SLOTS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtd_stream_if.sink   i_cmd,
    dtd_stream_if.source o_res
);

    // Classified commands from the front register into the queue
    dtd_stream_if #(.T(dtd_pkg::t_cmd)) front_q_if ();
    // Queue head into the dispatch engine
    dtd_stream_if #(.T(dtd_pkg::t_cmd)) queue_back_if ();

    // Front: accept the item, classify mode and range-check the slot id
    dtd_front #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_cmd),
        .o_cmd   (front_q_if.source)
    );

    // Short queue so the front keeps taking transfers while a poll drains
    dtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_q_if.sink),
        .o_cmd   (queue_back_if.source)
    );

    // Back: update the slot table, scan for the soonest deadline, dispatch
    dtd_back #(
        .TASK_SLOTS (TASK_SLOTS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_back_if.sink),
        .o_res   (o_res)
    );

endmodule

@@ dv/deadline_task_dispatcher_tb.sv @@
`timescale 1ns / 100ps

module deadline_task_dispatcher_tb;

    localparam int SLOT_COUNT   = 16;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 2 * SLOT_COUNT + 8;
    localparam int LONG_HOLD    = 300;

    // The package names the three live modes; the fourth code is left unused.
    localparam logic [dtd_pkg::ModeBits-1:0] MODE_UNUSED = 2'd3;

    // Timer table: mirrors the armed deadlines and queues the results that
    // each accepted command must produce, oldest first.
    class timer_table;
        logic [dtd_pkg::TimeW-1:0] deadline [SLOT_COUNT];
        bit                        armed    [SLOT_COUNT];
        dtd_pkg::t_result          due_results [$];
        int unsigned               mismatches;

        function new();
            foreach (deadline[i]) begin
                deadline[i] = '0;
                armed[i]    = 1'b0;
            end
            mismatches = 0;
        endfunction

        // Armed slot with the soonest deadline, lowest id on ties; -1 if none.
        function int soonest_slot();
            int best;
            best = -1;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (armed[i] && (best < 0 || deadline[i] < deadline[best])) begin
                    best = i;
                end
            end
            return best;
        endfunction

        function dtd_pkg::t_result status_after(bit fired, int slot, bit last);
            dtd_pkg::t_result r;
            int               s;
            s = soonest_slot();
            r.fired         = fired;
            r.fired_task    = fired ? slot[dtd_pkg::IdBits-1:0] : '0;
            r.last          = last;
            r.queue_empty   = (s < 0);
            r.next_deadline = (s < 0) ? '0 : deadline[s];
            return r;
        endfunction

        function void take_command(dtd_pkg::t_item it);
            dtd_pkg::t_result r;
            int               s;
            bit               any_fired;
            any_fired = 1'b0;
            if (it.mode == dtd_pkg::MODE_POLL) begin
                // Dispatch due slots soonest first; hold each result back one
                // step so the final one can be flagged.
                forever begin
                    s = soonest_slot();
                    if (s < 0 || deadline[s] > it.time_value) break;
                    armed[s] = 1'b0;
                    if (any_fired) due_results.push_back(r);
                    r = status_after(1'b1, s, 1'b0);
                    any_fired = 1'b1;
                end
                if (any_fired) begin
                    r.last = 1'b1;
                end else begin
                    r = status_after(1'b0, 0, 1'b1);
                end
                due_results.push_back(r);
            end else begin
                if (int'(it.task_id) < SLOT_COUNT) begin
                    if (it.mode == dtd_pkg::MODE_SCHED) begin
                        deadline[it.task_id] = it.time_value;
                        armed[it.task_id]    = 1'b1;
                    end else if (it.mode == dtd_pkg::MODE_CANCEL) begin
                        armed[it.task_id] = 1'b0;
                    end
                end
                due_results.push_back(status_after(1'b0, 0, 1'b1));
            end
        endfunction

        function void match_dispatch(dtd_pkg::t_result got);
            dtd_pkg::t_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: fired=%0d fired_task=%0d last=%0d",
                       got.fired, got.fired_task, got.last);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.fired !== want.fired) begin
                $error("fired: expected %0d, got %0d", want.fired, got.fired);
                mismatches++;
            end
            if (got.fired_task !== want.fired_task) begin
                $error("fired_task: expected %0d, got %0d", want.fired_task, got.fired_task);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
            if (got.queue_empty !== want.queue_empty) begin
                $error("queue_empty: expected %0d, got %0d",
                       want.queue_empty, got.queue_empty);
                mismatches++;
            end
            if (got.next_deadline !== want.next_deadline) begin
                $error("next_deadline: expected %0h, got %0h",
                       want.next_deadline, got.next_deadline);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dtd_stream_if #(.T(dtd_pkg::t_item))   cmd_if ();
    dtd_stream_if #(.T(dtd_pkg::t_result)) res_if ();

    deadline_task_dispatcher #(
        .TASK_SLOTS(SLOT_COUNT),
        .TIME_BITS (dtd_pkg::TimeW)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    timer_table                ledger;
    int                        tx_idle_pct;
    int                        rx_idle_pct;
    int                        hold_left;
    int                        cycle_count;
    logic [dtd_pkg::TimeW-1:0] now_tick;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Result side: drive ready at the falling edge. A pending hold-off wins
    // over the random idling and counts down one cycle at a time.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_if.ready = 1'b0;
            hold_left    = hold_left - 1;
        end else begin
            res_if.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every result transfer at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            ledger.match_dispatch(res_if.payload);
        end
    end

    // Watchdog: fail the run if it has not finished before the cycle limit runs out.
    initial begin
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) begin
            @(posedge i_clk);
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic dtd_pkg::t_item make_item(logic [dtd_pkg::ModeBits-1:0] mode,
                                                 logic [dtd_pkg::IdBits-1:0] id,
                                                 logic [dtd_pkg::TimeW-1:0] tv);
        dtd_pkg::t_item it;
        it.mode       = mode;
        it.task_id    = id;
        it.time_value = tv;
        return it;
    endfunction

    // Mostly well-formed traffic: deadlines a little ahead of a running clock
    // and polls that step that clock forward, so slots get armed, fire in
    // order and get rearmed. Sprinkle in far-off deadlines, full drains,
    // cancels, the unused mode and fully random noise.
    function automatic dtd_pkg::t_item random_command();
        dtd_pkg::t_item it;
        int unsigned    pick;
        pick          = $urandom_range(99);
        it.task_id    = dtd_pkg::IdBits'($urandom_range(SLOT_COUNT - 1));
        it.time_value = $urandom;
        if (pick < 48) begin
            it.mode = dtd_pkg::MODE_SCHED;
            if ($urandom_range(9) != 0) it.time_value = now_tick + $urandom_range(300);
        end else if (pick < 60) begin
            it.mode = dtd_pkg::MODE_CANCEL;
        end else if (pick < 92) begin
            it.mode = dtd_pkg::MODE_POLL;
            if ($urandom_range(19) == 0) begin
                it.time_value = '1;
            end else if ($urandom_range(19) != 0) begin
                now_tick      = now_tick + $urandom_range(120);
                it.time_value = now_tick;
            end
        end else if (pick < 96) begin
            it.mode = MODE_UNUSED;
        end else begin
            it.mode = dtd_pkg::ModeBits'($urandom_range(3));
        end
        return it;
    endfunction

    // Offer one command; call at a falling edge, return at a falling edge.
    // Valid stays high into the next command unless an idle cycle is drawn.
    task automatic send_item(dtd_pkg::t_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid   = 1'b1;
        cmd_if.payload = it;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        ledger.take_command(it);
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every predicted result has been checked.
    task automatic wait_all_dispatched();
        cmd_if.valid = 1'b0;
        while (ledger.due_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Change idling at a rising edge so the ready process sees it cleanly.
    task automatic set_idling(int tx_pct, int rx_pct, int hold);
        @(posedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        hold_left   = hold;
        @(negedge i_clk);
    endtask

    initial begin
        ledger         = new();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_left      = 0;
        now_tick       = '0;
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        res_if.ready   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_idling(8, 87, 0);

        // Directed: time extremes, a deadline tie, a reschedule, a cancel of an
        // idle slot, the unused mode, an early poll, and a drain in order.
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd0,  32'd0));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd15, 32'hFFFF_FFFF));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd5,  32'd100));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd6,  32'd100));
        send_item(make_item(dtd_pkg::MODE_POLL,   4'd9,  32'd0));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd5,  32'd50));
        send_item(make_item(dtd_pkg::MODE_CANCEL, 4'd7,  32'hFFFF_FFFF));
        send_item(make_item(dtd_pkg::MODE_CANCEL, 4'd15, 32'd0));
        send_item(make_item(MODE_UNUSED,          4'd15, 32'hA5A5_5A5A));
        send_item(make_item(dtd_pkg::MODE_POLL,   4'd0,  32'd99));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd5,  32'd100));
        send_item(make_item(dtd_pkg::MODE_POLL,   4'd15, 32'd100));
        send_item(make_item(dtd_pkg::MODE_POLL,   4'd3,  32'hFFFF_FFFF));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd3,  32'hFFFF_FFFF));
        send_item(make_item(dtd_pkg::MODE_SCHED,  4'd9,  32'd1));
        send_item(make_item(dtd_pkg::MODE_POLL,   4'd0,  32'hFFFF_FFFF));
        send_item(make_item(dtd_pkg::MODE_CANCEL, 4'd3,  32'd0));
        wait_all_dispatched();

        // Slow receiver: results pile up behind the back part.
        now_tick = $urandom_range(1000);
        repeat (100) send_item(random_command());
        wait_all_dispatched();

        // Slow sender: the block mostly waits on commands. Start high in the
        // time range so the upper deadline bits get exercised.
        set_idling(87, 8, 0);
        now_tick = $urandom;
        repeat (100) send_item(random_command());
        wait_all_dispatched();

        // Full rate, opened by a long receiver hold-off so the command queue
        // fills and the input stalls while the sender keeps offering.
        set_idling(0, 0, LONG_HOLD);
        now_tick = $urandom_range(1000);
        repeat (100) send_item(random_command());
        wait_all_dispatched();

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.due_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/dtd_pkg.sv
hdl/dtd_stream_if.sv
hdl/dtd_front.sv
hdl/dtd_fifo.sv
hdl/dtd_back.sv
hdl/deadline_task_dispatcher.sv
dv/deadline_task_dispatcher_tb.sv
